// ----- rtl/b64d_pkg.sv -----
`timescale 1ns / 1ps
// Shared types, constants and character decode for the base64 stream decoder.
package b64d_pkg;

   localparam int CHAR_W   = 8;
   localparam int SEXTET_W = 6;
   localparam int GROUP_W  = 2;

   localparam logic [CHAR_W-1:0]   CHAR_SPACE = 8'h20;
   localparam logic [CHAR_W-1:0]   CHAR_TAB   = 8'h09;
   localparam logic [CHAR_W-1:0]   CHAR_CR    = 8'h0D;
   localparam logic [CHAR_W-1:0]   CHAR_LF    = 8'h0A;
   localparam logic [CHAR_W-1:0]   CHAR_PAD   = 8'h3D;
   localparam logic [CHAR_W-1:0]   CHAR_PLUS  = 8'h2B;
   localparam logic [CHAR_W-1:0]   CHAR_SLASH = 8'h2F;
   localparam logic [CHAR_W-1:0]   CHAR_UPPER_A = 8'h41;
   localparam logic [CHAR_W-1:0]   CHAR_UPPER_Z = 8'h5A;
   localparam logic [CHAR_W-1:0]   CHAR_LOWER_A = 8'h61;
   localparam logic [CHAR_W-1:0]   CHAR_LOWER_Z = 8'h7A;
   localparam logic [CHAR_W-1:0]   CHAR_DIGIT_0 = 8'h30;
   localparam logic [CHAR_W-1:0]   CHAR_DIGIT_9 = 8'h39;

   localparam logic [CHAR_W-1:0]   LOWER_BASE   = 8'd26;
   localparam logic [CHAR_W-1:0]   DIGIT_BASE   = 8'd52;
   localparam logic [SEXTET_W-1:0] SEXTET_PLUS  = 6'd62;
   localparam logic [SEXTET_W-1:0] SEXTET_SLASH = 6'd63;

   // character classes
   typedef enum logic [1:0] {
      CLS_SKIP,   // whitespace
      CLS_PAD,    // '='
      CLS_DATA,   // alphabet character
      CLS_BAD     // anything else
   } char_class_type;

   typedef struct packed {
      char_class_type           cls;
      logic [SEXTET_W-1:0]      sextet;
   } char_info_type;

   typedef struct packed {
      logic [CHAR_W-1:0] out_byte;
      logic              byte_valid;
      logic              done_res;
      logic              decode_error;
   } result_type;

   function automatic char_info_type decode_char(input logic [CHAR_W-1:0] c);
      char_info_type info;
      info.cls    = CLS_BAD;
      info.sextet = '0;
      if (c == CHAR_SPACE || c == CHAR_TAB || c == CHAR_CR || c == CHAR_LF) begin
         info.cls = CLS_SKIP;
      end else if (c == CHAR_PAD) begin
         info.cls = CLS_PAD;
      end else if (c inside {[CHAR_UPPER_A:CHAR_UPPER_Z]}) begin
         info.cls    = CLS_DATA;
         info.sextet = SEXTET_W'(c - CHAR_UPPER_A);
      end else if (c inside {[CHAR_LOWER_A:CHAR_LOWER_Z]}) begin
         info.cls    = CLS_DATA;
         info.sextet = SEXTET_W'(c - CHAR_LOWER_A + LOWER_BASE);
      end else if (c inside {[CHAR_DIGIT_0:CHAR_DIGIT_9]}) begin
         info.cls    = CLS_DATA;
         info.sextet = SEXTET_W'(c - CHAR_DIGIT_0 + DIGIT_BASE);
      end else if (c == CHAR_PLUS) begin
         info.cls    = CLS_DATA;
         info.sextet = SEXTET_PLUS;
      end else if (c == CHAR_SLASH) begin
         info.cls    = CLS_DATA;
         info.sextet = SEXTET_SLASH;
      end
      return info;
   endfunction

endpackage

// ----- rtl/b64d_if.sv -----
`timescale 1ns / 1ps
// Valid/ready channel interfaces for the character input and the decoded result.
interface b64d_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] in_char;
   logic       is_final;

   modport source (output valid, output in_char, output is_final, input ready);
   modport sink   (input valid, input in_char, input is_final, output ready);
endinterface

interface b64d_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_byte;
   logic       byte_valid;
   logic       done_res;
   logic       decode_error;

   modport source (output valid, output out_byte, output byte_valid,
                   output done_res, output decode_error, input ready);
   modport sink   (input valid, input out_byte, input byte_valid,
                   input done_res, input decode_error, output ready);
endinterface

// ----- rtl/b64d_step.sv -----
`timescale 1ns / 1ps
// Decoder state and the per-character group assembly step.
module b64d_step (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                advance,
   input  b64d_pkg::char_info_type             info,
   input  logic                                last,
   output logic                                emit,
   output b64d_pkg::result_type                result
);

   logic [b64d_pkg::GROUP_W-1:0]  group_ff, group_in;
   logic [b64d_pkg::SEXTET_W-1:0] prior_ff, prior_in;
   logic                          pad_ff, pad_in;
   logic                          err_ff, err_in;

   logic [b64d_pkg::CHAR_W-1:0]   byte_val;
   logic                          have_byte;
   logic                          final_err;
   logic [b64d_pkg::SEXTET_W-1:0] v;

   assign v = info.sextet;

   always_comb begin
      group_in  = group_ff;
      prior_in  = prior_ff;
      pad_in    = pad_ff;
      err_in    = err_ff;
      have_byte = 1'b0;
      byte_val  = '0;
      case (info.cls)
         b64d_pkg::CLS_SKIP: begin
         end
         b64d_pkg::CLS_PAD: begin
            pad_in = 1'b1;
         end
         b64d_pkg::CLS_DATA: begin
            if (pad_ff) begin
               err_in = 1'b1;
            end else if (!err_ff) begin
               prior_in = v;
               case (group_ff)
                  2'd0: begin
                     group_in = 2'd1;
                  end
                  2'd1: begin
                     byte_val  = {prior_ff, v[5:4]};
                     have_byte = 1'b1;
                     group_in  = 2'd2;
                  end
                  2'd2: begin
                     byte_val  = {prior_ff[3:0], v[5:2]};
                     have_byte = 1'b1;
                     group_in  = 2'd3;
                  end
                  default: begin
                     byte_val  = {prior_ff[1:0], v};
                     have_byte = 1'b1;
                     group_in  = 2'd0;
                  end
               endcase
            end
         end
         default: begin
            err_in = 1'b1;
         end
      endcase
   end

   // a lone sextet left in the group at end of text is an error
   assign final_err = err_in || (group_in == 2'd1);

   always_comb begin
      if (last) begin
         emit                = 1'b1;
         result.byte_valid   = have_byte && !final_err;
         result.out_byte     = result.byte_valid ? byte_val : '0;
         result.done_res     = 1'b1;
         result.decode_error = final_err;
      end else begin
         emit                = have_byte && !err_in;
         result.byte_valid   = 1'b1;
         result.out_byte     = byte_val;
         result.done_res     = 1'b0;
         result.decode_error = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         group_ff <= '0;
         prior_ff <= '0;
         pad_ff   <= 1'b0;
         err_ff   <= 1'b0;
      end else if (advance) begin
         if (last) begin
            group_ff <= '0;
            prior_ff <= '0;
            pad_ff   <= 1'b0;
            err_ff   <= 1'b0;
         end else begin
            group_ff <= group_in;
            prior_ff <= prior_in;
            pad_ff   <= pad_in;
            err_ff   <= err_in;
         end
      end
   end

endmodule

// ----- rtl/base64_stream_decoder.sv -----
`timescale 1ns / 1ps
// Top level of the streaming base64 decoder.
//
// Usage:
//   req  - one character beat per accepted handshake (in_char, is_final).
//          Whitespace is skipped; '=' padding may only be followed by more
//          padding or whitespace.
//   rsp  - zero or one result beat per character. A decoded byte leaves on
//          the second, third and fourth sextet of each group. The character
//          flagged is_final always yields a beat with done_res=1; if
//          decode_error is set on it, every byte sent for the text is void.
// Timing: the accepting edge loads the character register, and the result
//          register is loaded once it can take a beat (it is empty or rsp
//          is ready); rsp.valid rises with that load. A character that
//          yields no beat clears the character register and updates the group state.
// Throughput: one character per cycle while rsp is not stalled; the only feedback
//          path is the group state update within the step stage.
// Stall: while rsp is stalled with a result held, one more character is
//          taken into the character register; req.ready then drops until
//          the result is taken. Nothing is dropped or repeated.
// Reset: synchronous, active high; clears both stage valids and the group,
//          padding and error state. The end of each text also clears it.
module base64_stream_decoder (
   input  logic              clock,
   input  logic              reset,
   b64d_req_if.sink          req,
   b64d_rsp_if.source        rsp
);

   // character stage
   logic                        cv_ff, cv_in;
   b64d_pkg::char_info_type     cinfo_ff;
   logic                        clast_ff;

   // result stage
   logic                        rv_ff, rv_in;
   b64d_pkg::result_type        res_ff;

   logic                        req_beat;
   logic                        advance;
   logic                        emit;
   b64d_pkg::result_type        step_res;

   // the character stage moves on whenever the result register can take a beat
   assign advance   = cv_ff && (!rv_ff || rsp.ready);
   assign req.ready = !cv_ff || advance;
   assign req_beat  = req.valid && req.ready;

   assign cv_in = req_beat ? 1'b1 : (advance ? 1'b0 : cv_ff);
   assign rv_in = (advance && emit) ? 1'b1 : ((rsp.ready) ? 1'b0 : rv_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         cv_ff <= 1'b0;
         rv_ff <= 1'b0;
      end else begin
         cv_ff <= cv_in;
         rv_ff <= rv_in;
      end
   end

   // payload registers, no reset
   always_ff @(posedge clock) begin
      if (req_beat) begin
         cinfo_ff <= b64d_pkg::decode_char(req.in_char);
         clast_ff <= req.is_final;
      end
      if (advance && emit) begin
         res_ff <= step_res;
      end
   end

   b64d_step u_step (
      .clock   (clock),
      .reset   (reset),
      .advance (advance),
      .info    (cinfo_ff),
      .last    (clast_ff),
      .emit    (emit),
      .result  (step_res)
   );

   assign rsp.valid        = rv_ff;
   assign rsp.out_byte     = res_ff.out_byte;
   assign rsp.byte_valid   = res_ff.byte_valid;
   assign rsp.done_res     = res_ff.done_res;
   assign rsp.decode_error = res_ff.decode_error;

endmodule

// ----- bench/b64d_checker.sv -----
`timescale 1ns / 1ps
// Checker for the base64 stream decoder: predicts each result beat and compares it.
module b64d_checker (
   input  logic       clock,
   input  logic       reset,
   b64d_req_if        req,
   b64d_rsp_if        rsp,
   output int         fail_count,
   output int         pending
);

   // predicted decoder state
   logic [b64d_pkg::GROUP_W-1:0]  group_pos;
   logic [b64d_pkg::SEXTET_W-1:0] last_sextet;
   logic                          pad_seen;
   logic                          err_seen;

   b64d_pkg::result_type decoded_q[$];

   initial begin
      fail_count = 0;
      pending    = 0;
   end

   task automatic report_mismatch(input string what);
      $display("%0t ns: %s", $time, what);
      fail_count++;
   endtask

   // one character beat: update the state, queue the result it causes, if any
   function automatic void decode_step(input logic [b64d_pkg::CHAR_W-1:0] c,
                                       input logic fin);
      b64d_pkg::char_class_type      cls;
      logic [b64d_pkg::SEXTET_W-1:0] s;
      logic                          have;
      logic [b64d_pkg::CHAR_W-1:0]   b;
      logic                          bad_text;
      b64d_pkg::result_type          r;
      cls  = b64d_pkg::CLS_BAD;
      s    = '0;
      have = 1'b0;
      b    = '0;
      if (c == b64d_pkg::CHAR_SPACE || c == b64d_pkg::CHAR_TAB ||
          c == b64d_pkg::CHAR_CR || c == b64d_pkg::CHAR_LF) begin
         cls = b64d_pkg::CLS_SKIP;
      end else if (c == b64d_pkg::CHAR_PAD) begin
         cls = b64d_pkg::CLS_PAD;
      end else if (c >= b64d_pkg::CHAR_UPPER_A && c <= b64d_pkg::CHAR_UPPER_Z) begin
         cls = b64d_pkg::CLS_DATA;
         s   = b64d_pkg::SEXTET_W'(c - b64d_pkg::CHAR_UPPER_A);
      end else if (c >= b64d_pkg::CHAR_LOWER_A && c <= b64d_pkg::CHAR_LOWER_Z) begin
         cls = b64d_pkg::CLS_DATA;
         s   = b64d_pkg::SEXTET_W'(c - b64d_pkg::CHAR_LOWER_A + b64d_pkg::LOWER_BASE);
      end else if (c >= b64d_pkg::CHAR_DIGIT_0 && c <= b64d_pkg::CHAR_DIGIT_9) begin
         cls = b64d_pkg::CLS_DATA;
         s   = b64d_pkg::SEXTET_W'(c - b64d_pkg::CHAR_DIGIT_0 + b64d_pkg::DIGIT_BASE);
      end else if (c == b64d_pkg::CHAR_PLUS) begin
         cls = b64d_pkg::CLS_DATA;
         s   = b64d_pkg::SEXTET_PLUS;
      end else if (c == b64d_pkg::CHAR_SLASH) begin
         cls = b64d_pkg::CLS_DATA;
         s   = b64d_pkg::SEXTET_SLASH;
      end

      case (cls)
         b64d_pkg::CLS_PAD: begin
            pad_seen = 1'b1;
         end
         b64d_pkg::CLS_BAD: begin
            err_seen = 1'b1;
         end
         b64d_pkg::CLS_DATA: begin
            if (pad_seen) begin
               err_seen = 1'b1;
            end else if (!err_seen) begin
               case (group_pos)
                  2'd0: begin
                     group_pos = 2'd1;
                  end
                  2'd1: begin
                     b         = {last_sextet, s[5:4]};
                     have      = 1'b1;
                     group_pos = 2'd2;
                  end
                  2'd2: begin
                     b         = {last_sextet[3:0], s[5:2]};
                     have      = 1'b1;
                     group_pos = 2'd3;
                  end
                  default: begin
                     b         = {last_sextet[1:0], s};
                     have      = 1'b1;
                     group_pos = 2'd0;
                  end
               endcase
               last_sextet = s;
            end
         end
         default: ;
      endcase

      if (!fin) begin
         if (have && !err_seen) begin
            r.out_byte     = b;
            r.byte_valid   = 1'b1;
            r.done_res     = 1'b0;
            r.decode_error = 1'b0;
            decoded_q.insert(decoded_q.size(), r);
         end
      end else begin
         // a lone sextet left in the group spoils the text as well
         bad_text       = err_seen || group_pos == 2'd1;
         r.out_byte     = (have && !bad_text) ? b : '0;
         r.byte_valid   = have && !bad_text;
         r.done_res     = 1'b1;
         r.decode_error = bad_text;
         decoded_q.insert(decoded_q.size(), r);
         group_pos   = '0;
         last_sextet = '0;
         pad_seen    = 1'b0;
         err_seen    = 1'b0;
      end
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         group_pos   = '0;
         last_sextet = '0;
         pad_seen    = 1'b0;
         err_seen    = 1'b0;
         decoded_q.delete();
      end else begin
         if (rsp.valid && rsp.ready) begin
            if (decoded_q.size() == 0) begin
               report_mismatch($sformatf(
                  "unexpected result beat byte=%02h bv=%0b done=%0b err=%0b",
                  rsp.out_byte, rsp.byte_valid, rsp.done_res, rsp.decode_error));
            end else begin
               b64d_pkg::result_type want;
               want = decoded_q.pop_front();
               if (rsp.out_byte !== want.out_byte)
                  report_mismatch($sformatf("out_byte %02h, expected %02h",
                                  rsp.out_byte, want.out_byte));
               if (rsp.byte_valid !== want.byte_valid)
                  report_mismatch($sformatf("byte_valid %0b, expected %0b",
                                  rsp.byte_valid, want.byte_valid));
               if (rsp.done_res !== want.done_res)
                  report_mismatch($sformatf("done_res %0b, expected %0b",
                                  rsp.done_res, want.done_res));
               if (rsp.decode_error !== want.decode_error)
                  report_mismatch($sformatf("decode_error %0b, expected %0b",
                                  rsp.decode_error, want.decode_error));
            end
         end
         if (req.valid && req.ready) begin
            decode_step(req.in_char, req.is_final);
         end
      end
      pending = decoded_q.size();
   end

endmodule

// ----- bench/testbench.sv -----
`timescale 1ns / 1ps
// Top of the base64 stream decoder bench: clock, reset, character stimulus and verdict.
module testbench;

   logic clock;
   logic reset;
   int   fail_count;
   int   pending;

   // sender idle and receiver stall chances, in percent, per phase
   int   idle_pct;
   int   stall_pct;
   int   sent_count;

   // characters of the text being built, sent in order with is_final on the last
   logic [b64d_pkg::CHAR_W-1:0] text_q[$];

   b64d_req_if req_if ();
   b64d_rsp_if rsp_if ();

   base64_stream_decoder i_dut (
      .clock (clock),
      .reset (reset),
      .req   (req_if),
      .rsp   (rsp_if)
   );

   b64d_checker i_checker (
      .clock      (clock),
      .reset      (reset),
      .req        (req_if),
      .rsp        (rsp_if),
      .fail_count (fail_count),
      .pending    (pending)
   );

   // 10 ns clock
   initial clock = 1'b0;
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // receiver: ready is redrawn every cycle at the falling edge
   always @(negedge clock) begin
      rsp_if.ready <= ($urandom_range(99) >= stall_pct);
   end

   // hard stop well past the slowest correct run
   initial begin
      #5_000_000;
      $display("base64_stream_decoder: mismatch");
      $finish;
   end

   // alphabet character for a sextet
   function automatic logic [b64d_pkg::CHAR_W-1:0] sextet_char(
         input logic [b64d_pkg::SEXTET_W-1:0] s);
      if (s < 6'd26) return b64d_pkg::CHAR_W'(b64d_pkg::CHAR_UPPER_A + s);
      if (s < 6'd52) return b64d_pkg::CHAR_W'(b64d_pkg::CHAR_LOWER_A + s - 6'd26);
      if (s < b64d_pkg::SEXTET_PLUS)
         return b64d_pkg::CHAR_W'(b64d_pkg::CHAR_DIGIT_0 + s - 6'd52);
      if (s == b64d_pkg::SEXTET_PLUS) return b64d_pkg::CHAR_PLUS;
      return b64d_pkg::CHAR_SLASH;
   endfunction

   function automatic logic [b64d_pkg::CHAR_W-1:0] blank_char();
      case ($urandom_range(3))
         0:       return b64d_pkg::CHAR_SPACE;
         1:       return b64d_pkg::CHAR_TAB;
         2:       return b64d_pkg::CHAR_CR;
         default: return b64d_pkg::CHAR_LF;
      endcase
   endfunction

   // anything at all: raw byte, alphabet, padding or whitespace
   function automatic logic [b64d_pkg::CHAR_W-1:0] noise_char();
      case ($urandom_range(3))
         0:       return b64d_pkg::CHAR_W'($urandom_range(255));
         1:       return sextet_char(b64d_pkg::SEXTET_W'($urandom_range(63)));
         2:       return b64d_pkg::CHAR_PAD;
         default: return blank_char();
      endcase
   endfunction

   // append one character to the text being built
   task automatic add_char(input logic [b64d_pkg::CHAR_W-1:0] c);
      text_q.insert(text_q.size(), c);
   endtask

   // one character beat; entered and left at a falling edge so that valid is
   // assigned once per step (held high straight into the next beat unless an idle gap is drawn)
   task automatic send_char(input logic [b64d_pkg::CHAR_W-1:0] c, input logic fin);
      while ($urandom_range(99) < idle_pct) begin
         req_if.valid <= 1'b0;
         @(negedge clock);
      end
      req_if.valid    <= 1'b1;
      req_if.in_char  <= c;
      req_if.is_final <= fin;
      do @(posedge clock); while (!req_if.ready);
      @(negedge clock);
      sent_count++;
   endtask

   task automatic send_text();
      foreach (text_q[i]) send_char(text_q[i], i == text_q.size() - 1);
   endtask

   task automatic send_string(input string s);
      text_q.delete();
      for (int i = 0; i < s.len(); i++) add_char(s[i]);
      send_text();
   endtask

   // well-formed encoding of random bytes, whitespace sprinkled in; padding
   // is sometimes left off, which the decoder accepts
   task automatic build_clean();
      int          nbytes;
      int          rem;
      bit          use_pad;
      logic [23:0] w;
      logic [b64d_pkg::CHAR_W-1:0] grp[4];
      nbytes  = ($urandom_range(9) == 0) ? $urandom_range(48, 10) : $urandom_range(1, 6);
      use_pad = ($urandom_range(4) != 0);
      text_q.delete();
      for (int i = 0; i < nbytes; i += 3) begin
         rem = nbytes - i;
         w   = 24'($urandom);
         if (rem < 3) w[7:0]  = '0;
         if (rem < 2) w[15:8] = '0;
         grp[0] = sextet_char(w[23:18]);
         grp[1] = sextet_char(w[17:12]);
         grp[2] = (rem > 1) ? sextet_char(w[11:6]) : b64d_pkg::CHAR_PAD;
         grp[3] = (rem > 2) ? sextet_char(w[5:0])  : b64d_pkg::CHAR_PAD;
         foreach (grp[k]) begin
            if ($urandom_range(9) == 0) add_char(blank_char());
            if (grp[k] != b64d_pkg::CHAR_PAD || use_pad) add_char(grp[k]);
         end
      end
      if ($urandom_range(5) == 0) add_char(blank_char());
   endtask

   initial begin
      reset           = 1'b1;
      req_if.valid    = 1'b0;
      req_if.in_char  = '0;
      req_if.is_final = 1'b0;
      rsp_if.ready    = 1'b0;
      idle_pct        = 0;
      stall_pct       = 0;
      sent_count      = 0;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed: all-ones sextets, all-zero byte with double padding,
      // lone leftover sextet, data after padding, plus and slash, padding
      // alone, both extreme invalid bytes, every whitespace with a final LF
      send_string("////");
      send_string("AA==");
      send_string("A");
      send_string("Q=A");
      send_string("+/");
      send_string("=");
      text_q.delete();
      add_char(8'h00);
      send_text();
      text_q.delete();
      add_char(8'hFF);
      send_text();
      text_q.delete();
      add_char(b64d_pkg::CHAR_SPACE);
      add_char(b64d_pkg::CHAR_TAB);
      add_char(8'h7A);
      add_char(b64d_pkg::CHAR_CR);
      add_char(8'h39);
      add_char(b64d_pkg::CHAR_LF);
      send_text();

      // random texts over four idling phases: none, sender gaps,
      // receiver stalls, both
      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            0:       begin idle_pct = 0;  stall_pct = 0;  end
            1:       begin idle_pct = 48; stall_pct = 0;  end
            2:       begin idle_pct = 0;  stall_pct = 48; end
            default: begin idle_pct = 34; stall_pct = 34; end
         endcase
         while (sent_count < 23 + 163 * (phase + 1)) begin
            int pick;
            pick = $urandom_range(99);
            if (pick < 88) begin
               build_clean();
               if (pick >= 80) begin
                  // one character anywhere replaced by noise
                  text_q[$urandom_range(text_q.size() - 1)] = noise_char();
               end else if (pick >= 72) begin
                  // trailing data char: lone sextet, data after padding, or one more sextet of the last group
                  add_char(sextet_char(b64d_pkg::SEXTET_W'($urandom_range(63))));
               end
            end else begin
               text_q.delete();
               repeat ($urandom_range(1, 8)) add_char(noise_char());
            end
            send_text();
         end
      end

      req_if.valid <= 1'b0;
      while (pending != 0) @(negedge clock);
      // extra margin for any stray beat
      repeat (6) @(negedge clock);
      if (fail_count == 0) begin
         $display("base64_stream_decoder: match");
      end else begin
         $display("base64_stream_decoder: mismatch");
      end
      $finish;
   end

endmodule

// ----- sim.f -----
rtl/b64d_pkg.sv
rtl/b64d_if.sv
rtl/b64d_step.sv
rtl/base64_stream_decoder.sv
bench/b64d_checker.sv
bench/testbench.sv
